// ===== rtl/core/rvde_pkg.sv =====
// Shared types and constants for the RV32I decode/execute block.
// Used by every module under rtl/core except rvde_ram; no dependencies of its own.
package rvde_pkg;

   localparam int MEM_BYTES_DEFAULT = 65536;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_ALUI   = 7'h13;
   localparam logic [6:0] OPC_ALUR   = 7'h33;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   localparam logic [2:0] F3_SB = 3'd0;
   localparam logic [2:0] F3_SH = 3'd1;
   localparam logic [2:0] F3_SW = 3'd2;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   typedef enum logic [3:0] {
      OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD, OP_STORE,
      OP_ALUI, OP_ALUR, OP_PRELOAD, OP_ILLEGAL
   } op_class_type;

   typedef struct packed {
      op_class_type op;
      logic [2:0]   f3;
      logic         alt;
      logic         has_rd;
      logic [4:0]   rd;
      logic [4:0]   rs1;
      logic [4:0]   rs2;
      logic [31:0]  imm;
      logic [15:0]  paddr;
      logic [7:0]   pbyte;
   } item_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        dest_written;
      logic        illegal;
   } result_type;

endpackage

// ===== rtl/core/rv32i_decode_execute.sv =====
// RV32I decode/execute block, top level.
// Request channel (req_*): valid/ready. req_command 0 executes req_instr_word,
//   1 writes req_preload_byte to data memory at req_preload_addr.
// Response channel (rsp_*): valid/ready, one response per request, in order:
//   next pc, destination register and value written, and the illegal flag.
// Configuration (csr_*): a write loads the program counter with
//   csr_write_data at once; write only while no request is in flight.
// Path: queue, execute stage, write-back stage, then the output register.
// Throughput: one request per cycle unless the response channel stalls; the
//   register file is read one stage ahead with bypasses, and data memory is
//   four byte-wide banks; a word access of any alignment hits each bank once.
// Reset: pc clears to 0, the register file reads zero, the queue and
//   pipeline empty. Data memory is not cleared.
// Stalls: while rsp_ready is low and a response waits, the back end holds; the
//   two-entry request queue keeps taking requests until it is full.
// Depends on rvde_pkg, rvde_front, rvde_back, rvde_ram.
module rv32i_decode_execute #(
   parameter int MEM_BYTES   = rvde_pkg::MEM_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = rvde_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_instr_word,
   input  logic [15:0] req_preload_addr,
   input  logic [7:0]  req_preload_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_dest_written,
   output logic        rsp_illegal
);
   logic                 head_valid, head_pop;
   rvde_pkg::item_type   head_item;
   logic                 back_valid, back_ready;
   rvde_pkg::result_type back_result;
   logic                 rsp_valid_ff;
   rvde_pkg::result_type rsp_ff;

   rvde_front #(.QueueDepth(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_instr_word(req_instr_word), .req_preload_addr(req_preload_addr),
      .req_preload_byte(req_preload_byte),
      .head_valid(head_valid), .head_item(head_item), .head_pop(head_pop)
   );

   rvde_back #(.MemBytes(MEM_BYTES)) u_back (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .head_valid(head_valid), .head_item(head_item), .head_pop(head_pop),
      .out_ready(back_ready), .out_valid(back_valid), .out_result(back_result)
   );

   // output register: advance when empty or being taken
   assign back_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_ready) begin
         rsp_valid_ff <= back_valid;
      end
      if (back_ready && back_valid) begin
         rsp_ff <= back_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_ff.next_pc;
   assign rsp_dest_index   = rsp_ff.dest_index;
   assign rsp_dest_value   = rsp_ff.dest_value;
   assign rsp_dest_written = rsp_ff.dest_written;
   assign rsp_illegal      = rsp_ff.illegal;
endmodule

// ===== rtl/core/rvde_ram.sv =====
// Generic simple dual-port RAM: one write and one read address per cycle.
// Read data is registered and holds while rd_en is low. No dependencies.
module rvde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/rvde_front.sv =====
// Front end: accepts requests, decodes and classifies them, queues them.
// Depends on rvde_pkg.
module rvde_front #(
   parameter int QueueDepth = rvde_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [31:0]        req_instr_word,
   input  logic [15:0]        req_preload_addr,
   input  logic [7:0]         req_preload_byte,
   output logic               head_valid,
   output rvde_pkg::item_type head_item,
   input  logic               head_pop
);
   localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CW = $clog2(QueueDepth + 1);

   rvde_pkg::item_type q_ff [QueueDepth];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push, pop;
   rvde_pkg::item_type dec;
   logic [31:0] w;
   logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;

   always_comb begin
      w     = req_instr_word;
      imm_i = {{21{w[31]}}, w[30:20]};
      imm_s = {{21{w[31]}}, w[30:25], w[11:7]};
      imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      imm_u = {w[31:12], 12'b0};
      imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      dec.f3     = w[14:12];
      dec.alt    = w[30];
      dec.rd     = w[11:7];
      dec.rs1    = w[19:15];
      dec.rs2    = w[24:20];
      dec.paddr  = req_preload_addr;
      dec.pbyte  = req_preload_byte;
      dec.imm    = imm_i;
      dec.op     = rvde_pkg::OP_ILLEGAL;
      case (w[6:0])
         rvde_pkg::OPC_LUI: begin
            dec.op  = rvde_pkg::OP_LUI;
            dec.imm = imm_u;
         end
         rvde_pkg::OPC_AUIPC: begin
            dec.op  = rvde_pkg::OP_AUIPC;
            dec.imm = imm_u;
         end
         rvde_pkg::OPC_JAL: begin
            dec.op  = rvde_pkg::OP_JAL;
            dec.imm = imm_j;
         end
         rvde_pkg::OPC_JALR: dec.op = rvde_pkg::OP_JALR;
         rvde_pkg::OPC_BRANCH: begin
            dec.imm = imm_b;
            if (dec.f3 inside {rvde_pkg::F3_BEQ, rvde_pkg::F3_BNE, rvde_pkg::F3_BLT,
                               rvde_pkg::F3_BGE, rvde_pkg::F3_BLTU, rvde_pkg::F3_BGEU}) begin
               dec.op = rvde_pkg::OP_BRANCH;
            end
         end
         rvde_pkg::OPC_LOAD: begin
            if (dec.f3 inside {rvde_pkg::F3_LB, rvde_pkg::F3_LH, rvde_pkg::F3_LW,
                               rvde_pkg::F3_LBU, rvde_pkg::F3_LHU}) begin
               dec.op = rvde_pkg::OP_LOAD;
            end
         end
         rvde_pkg::OPC_STORE: begin
            dec.imm = imm_s;
            if (dec.f3 inside {rvde_pkg::F3_SB, rvde_pkg::F3_SH, rvde_pkg::F3_SW}) begin
               dec.op = rvde_pkg::OP_STORE;
            end
         end
         rvde_pkg::OPC_ALUI: dec.op = rvde_pkg::OP_ALUI;
         rvde_pkg::OPC_ALUR: dec.op = rvde_pkg::OP_ALUR;
         default: dec.op = rvde_pkg::OP_ILLEGAL;
      endcase
      if (req_command) begin
         dec.op = rvde_pkg::OP_PRELOAD;
      end
      dec.has_rd = (dec.rd != 5'd0) &&
                   (dec.op inside {rvde_pkg::OP_LUI, rvde_pkg::OP_AUIPC, rvde_pkg::OP_JAL,
                                   rvde_pkg::OP_JALR, rvde_pkg::OP_LOAD, rvde_pkg::OP_ALUI,
                                   rvde_pkg::OP_ALUR});
   end

   assign req_ready  = (count_ff != CW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_item  = q_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

// ===== rtl/core/rvde_back.sv =====
// Back end: register read, execute (pc, ALU, memory issue), load format and
// write-back. Depends on rvde_pkg and rvde_ram.
module rvde_back #(
   parameter int MemBytes = rvde_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data,
   input  logic                 head_valid,
   input  rvde_pkg::item_type   head_item,
   output logic                 head_pop,
   input  logic                 out_ready,
   output logic                 out_valid,
   output rvde_pkg::result_type out_result
);
   localparam int AW   = $clog2(MemBytes);
   localparam int RW   = AW - 2;
   localparam int ROWS = MemBytes / 4;

   logic adv;
   logic [31:0] pc_ff;
   logic [31:0] rf_valid_ff;

   // execute stage
   logic               e_valid_ff;
   rvde_pkg::item_type e_item_ff;
   logic               va_ff, vb_ff;
   logic [31:0]        rf_a_q, rf_b_q;
   logic               lc_we_ff;
   logic [4:0]         lc_rd_ff;
   logic [31:0]        lc_val_ff;

   // write-back stage
   logic        w_valid_ff, w_wr_ff, w_load_ff, w_illegal_ff;
   logic [4:0]  w_rd_ff;
   logic [31:0] w_val_ff, w_npc_ff;
   logic [2:0]  w_f3_ff;
   logic [1:0]  w_lo_ff;

   logic [31:0] a_op, b_op, alu_b, alu_res, sum, seq, e_npc, e_val;
   logic        e_wr, e_load, e_bad, take;
   logic [AW-1:0] mem_ad;
   logic [1:0]    bank_off [4];
   logic [RW-1:0] bank_row [4];
   logic [7:0]    bank_wdata [4];
   logic          bank_we [4];
   logic [7:0]    bank_q [4];
   logic [7:0]    ld_byte [4];
   logic [31:0]   ld_word, ld_val, w_value;
   logic          commit;

   assign adv      = out_ready;
   assign head_pop = adv;
   assign commit   = adv && w_valid_ff && w_wr_ff;

   rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock(clock), .wr_en(commit), .wr_addr(w_rd_ff), .wr_data(w_value),
      .rd_en(adv), .rd_addr(head_item.rs1), .rd_data(rf_a_q)
   );
   rvde_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock(clock), .wr_en(commit), .wr_addr(w_rd_ff), .wr_data(w_value),
      .rd_en(adv), .rd_addr(head_item.rs2), .rd_data(rf_b_q)
   );

   // operands: write-back stage first, then the value committed as this one was read
   always_comb begin
      a_op = va_ff ? rf_a_q : 32'd0;
      b_op = vb_ff ? rf_b_q : 32'd0;
      if (lc_we_ff && lc_rd_ff == e_item_ff.rs1) a_op = lc_val_ff;
      if (lc_we_ff && lc_rd_ff == e_item_ff.rs2) b_op = lc_val_ff;
      if (w_valid_ff && w_wr_ff && w_rd_ff == e_item_ff.rs1) a_op = w_value;
      if (w_valid_ff && w_wr_ff && w_rd_ff == e_item_ff.rs2) b_op = w_value;
   end

   always_comb begin
      alu_b = (e_item_ff.op == rvde_pkg::OP_ALUR) ? b_op : e_item_ff.imm;
      case (e_item_ff.f3)
         rvde_pkg::F3_ADD:
            alu_res = (e_item_ff.op == rvde_pkg::OP_ALUR && e_item_ff.alt) ?
                      a_op - alu_b : a_op + alu_b;
         rvde_pkg::F3_SLL:  alu_res = a_op << alu_b[4:0];
         rvde_pkg::F3_SLT:  alu_res = {31'd0, $signed(a_op) < $signed(alu_b)};
         rvde_pkg::F3_SLTU: alu_res = {31'd0, a_op < alu_b};
         rvde_pkg::F3_XOR:  alu_res = a_op ^ alu_b;
         rvde_pkg::F3_SR:
            alu_res = e_item_ff.alt ? 32'($signed(a_op) >>> alu_b[4:0]) : a_op >> alu_b[4:0];
         rvde_pkg::F3_OR:   alu_res = a_op | alu_b;
         default:           alu_res = a_op & alu_b;
      endcase
   end

   always_comb begin
      case (e_item_ff.f3)
         rvde_pkg::F3_BEQ:  take = (a_op == b_op);
         rvde_pkg::F3_BNE:  take = (a_op != b_op);
         rvde_pkg::F3_BLT:  take = $signed(a_op) < $signed(b_op);
         rvde_pkg::F3_BGE:  take = $signed(a_op) >= $signed(b_op);
         rvde_pkg::F3_BLTU: take = a_op < b_op;
         rvde_pkg::F3_BGEU: take = a_op >= b_op;
         default:           take = 1'b0;
      endcase
   end

   always_comb begin
      sum    = a_op + e_item_ff.imm;
      seq    = pc_ff + 32'd4;
      e_npc  = seq;
      e_val  = 32'd0;
      e_load = 1'b0;
      e_bad  = 1'b0;
      case (e_item_ff.op)
         rvde_pkg::OP_LUI:    e_val = e_item_ff.imm;
         rvde_pkg::OP_AUIPC:  e_val = pc_ff + e_item_ff.imm;
         rvde_pkg::OP_JAL: begin
            e_val = seq;
            e_npc = pc_ff + e_item_ff.imm;
         end
         rvde_pkg::OP_JALR: begin
            e_val = seq;
            e_npc = {sum[31:1], 1'b0};
         end
         rvde_pkg::OP_BRANCH: e_npc = take ? pc_ff + e_item_ff.imm : seq;
         rvde_pkg::OP_LOAD:   e_load = 1'b1;
         rvde_pkg::OP_STORE:  e_val = 32'd0;
         rvde_pkg::OP_ALUI,
         rvde_pkg::OP_ALUR:   e_val = alu_res;
         rvde_pkg::OP_PRELOAD: e_npc = pc_ff;
         default: begin
            e_bad = 1'b1;
            e_npc = pc_ff;
         end
      endcase
      e_wr = e_item_ff.has_rd && !e_bad;
   end

   // byte lanes: bank k holds addresses with low bits k
   always_comb begin
      mem_ad = (e_item_ff.op == rvde_pkg::OP_PRELOAD) ? AW'(e_item_ff.paddr) : AW'(sum);
      for (int k = 0; k < 4; k++) begin
         bank_off[k]   = 2'(k) - mem_ad[1:0];
         bank_row[k]   = RW'((mem_ad + AW'(bank_off[k])) >> 2);
         bank_wdata[k] = (e_item_ff.op == rvde_pkg::OP_PRELOAD) ?
                         e_item_ff.pbyte : b_op[8*bank_off[k] +: 8];
         if (e_item_ff.op == rvde_pkg::OP_PRELOAD) begin
            bank_we[k] = adv && e_valid_ff && (bank_off[k] == 2'd0);
         end else if (e_item_ff.op == rvde_pkg::OP_STORE) begin
            case (e_item_ff.f3)
               rvde_pkg::F3_SB: bank_we[k] = adv && e_valid_ff && (bank_off[k] == 2'd0);
               rvde_pkg::F3_SH: bank_we[k] = adv && e_valid_ff && (bank_off[k] <= 2'd1);
               default:         bank_we[k] = adv && e_valid_ff;
            endcase
         end else begin
            bank_we[k] = 1'b0;
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      rvde_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
         .clock(clock), .wr_en(bank_we[g]), .wr_addr(bank_row[g]), .wr_data(bank_wdata[g]),
         .rd_en(adv && e_valid_ff && e_load), .rd_addr(bank_row[g]), .rd_data(bank_q[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ld_byte[i] = bank_q[2'(w_lo_ff + 2'(i))];
      end
      ld_word = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
      case (w_f3_ff)
         rvde_pkg::F3_LB:  ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
         rvde_pkg::F3_LH:  ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
         rvde_pkg::F3_LBU: ld_val = {24'd0, ld_word[7:0]};
         rvde_pkg::F3_LHU: ld_val = {16'd0, ld_word[15:0]};
         default:          ld_val = ld_word;
      endcase
      w_value = w_load_ff ? ld_val : w_val_ff;
   end

   assign out_valid               = w_valid_ff;
   assign out_result.next_pc      = w_npc_ff;
   assign out_result.dest_index   = w_wr_ff ? w_rd_ff : 5'd0;
   assign out_result.dest_value   = w_wr_ff ? w_value : 32'd0;
   assign out_result.dest_written = w_wr_ff;
   assign out_result.illegal      = w_illegal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff       <= 32'd0;
         rf_valid_ff <= '0;
         e_valid_ff  <= 1'b0;
         w_valid_ff  <= 1'b0;
         lc_we_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end else if (adv && e_valid_ff) begin
            pc_ff <= e_npc;
         end
         if (commit) begin
            rf_valid_ff[w_rd_ff] <= 1'b1;
         end
         if (adv) begin
            e_valid_ff <= head_valid;
            w_valid_ff <= e_valid_ff;
            lc_we_ff   <= commit;
         end
      end
      if (adv) begin
         e_item_ff    <= head_item;
         va_ff        <= rf_valid_ff[head_item.rs1];
         vb_ff        <= rf_valid_ff[head_item.rs2];
         lc_rd_ff     <= w_rd_ff;
         lc_val_ff    <= w_value;
         w_wr_ff      <= e_wr;
         w_load_ff    <= e_load;
         w_illegal_ff <= e_bad;
         w_rd_ff      <= e_item_ff.rd;
         w_val_ff     <= e_val;
         w_npc_ff     <= e_npc;
         w_f3_ff      <= e_item_ff.f3;
         w_lo_ff      <= mem_ad[1:0];
      end
   end

   a_no_x0_write : assert property (@(posedge clock) disable iff (reset)
      w_valid_ff && w_wr_ff |-> w_rd_ff != 5'd0)
      else $error("write-back targets x0");

   a_illegal_no_write : assert property (@(posedge clock) disable iff (reset)
      w_valid_ff && w_illegal_ff |-> !w_wr_ff && !w_load_ff)
      else $error("illegal item writes a register");

   a_illegal_holds_pc : assert property (@(posedge clock) disable iff (reset)
      adv && e_valid_ff && e_bad && !csr_write_enable |=> pc_ff == $past(pc_ff))
      else $error("illegal item moved pc");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !adv && !csr_write_enable |=> $stable(pc_ff) && $stable(w_valid_ff))
      else $error("back end moved while stalled");

endmodule

// ===== tb/sv/rvde_checker.sv =====
// Checker for rv32i_decode_execute: watches request and response channels,
// runs its own RV32I model, and compares every response. Depends on rvde_pkg.
module rvde_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_instr_word,
   input  logic [15:0] req_preload_addr,
   input  logic [7:0]  req_preload_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_next_pc,
   input  logic [4:0]  rsp_dest_index,
   input  logic [31:0] rsp_dest_value,
   input  logic        rsp_dest_written,
   input  logic        rsp_illegal,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_SIZE = rvde_pkg::MEM_BYTES_DEFAULT;

   logic [31:0] regs [32];
   logic [31:0] pc;
   logic [7:0]  mem [MEM_SIZE];
   rvde_pkg::result_type expected_q [$];

   function automatic logic [31:0] sext_i(logic [31:0] w);
      return {{21{w[31]}}, w[30:20]};
   endfunction

   function automatic logic [31:0] load_bytes(logic [31:0] ad, int n);
      logic [31:0] v;
      v = 0;
      for (int i = 0; i < n; i++)
         v |= 32'(mem[(ad + i) % MEM_SIZE]) << (8 * i);
      return v;
   endfunction

   function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                          logic [31:0] b, logic is_reg);
      case (f3)
         rvde_pkg::F3_ADD:  return (is_reg && alt) ? a - b : a + b;
         rvde_pkg::F3_SLL:  return a << b[4:0];
         rvde_pkg::F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         rvde_pkg::F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
         rvde_pkg::F3_XOR:  return a ^ b;
         rvde_pkg::F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
         rvde_pkg::F3_OR:   return a | b;
         default:           return a & b;
      endcase
   endfunction

   // Advance the model by one request and return the response it predicts.
   function automatic rvde_pkg::result_type execute_request(logic cmd, logic [31:0] w,
                                                            logic [15:0] paddr,
                                                            logic [7:0] pbyte);
      rvde_pkg::result_type r;
      logic [31:0] npc, a, b, val, ad, imm;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic        has_rd, bad, take, alt;
      r = '0;
      r.next_pc = pc;
      if (cmd) begin
         mem[paddr % MEM_SIZE] = pbyte;
         return r;
      end
      npc = pc + 4;
      rd = w[11:7];
      f3 = w[14:12];
      a = regs[w[19:15]];
      b = regs[w[24:20]];
      alt = w[30];
      has_rd = 0; bad = 0; val = 0; take = 0;
      case (w[6:0])
         rvde_pkg::OPC_LUI: begin has_rd = 1; val = {w[31:12], 12'd0}; end
         rvde_pkg::OPC_AUIPC: begin has_rd = 1; val = pc + {w[31:12], 12'd0}; end
         rvde_pkg::OPC_JAL: begin
            has_rd = 1; val = pc + 4;
            npc = pc + {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
         end
         rvde_pkg::OPC_JALR: begin
            has_rd = 1; val = pc + 4;
            npc = (a + sext_i(w)) & 32'hffff_fffe;
         end
         rvde_pkg::OPC_BRANCH: begin
            case (f3)
               rvde_pkg::F3_BEQ:  take = a == b;
               rvde_pkg::F3_BNE:  take = a != b;
               rvde_pkg::F3_BLT:  take = $signed(a) < $signed(b);
               rvde_pkg::F3_BGE:  take = !($signed(a) < $signed(b));
               rvde_pkg::F3_BLTU: take = a < b;
               rvde_pkg::F3_BGEU: take = a >= b;
               default:           bad = 1;
            endcase
            if (take) npc = pc + {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
         end
         rvde_pkg::OPC_LOAD: begin
            ad = a + sext_i(w);
            has_rd = 1;
            case (f3)
               rvde_pkg::F3_LB:  val = load_bytes(ad, 1);
               rvde_pkg::F3_LH:  begin
                  val = load_bytes(ad, 2);
                  if (val[15]) val |= 32'hffff0000;
               end
               rvde_pkg::F3_LW:  val = load_bytes(ad, 4);
               rvde_pkg::F3_LBU: val = load_bytes(ad, 1);
               rvde_pkg::F3_LHU: val = load_bytes(ad, 2);
               default:          bad = 1;
            endcase
            if (!bad && f3 == rvde_pkg::F3_LB) val = {{24{val[7]}}, val[7:0]};
         end
         rvde_pkg::OPC_STORE: begin
            imm = {{21{w[31]}}, w[30:25], w[11:7]};
            ad = a + imm;
            if (f3 <= rvde_pkg::F3_SW) begin
               for (int i = 0; i < (1 << f3); i++)
                  mem[(ad + i) % MEM_SIZE] = b[8*i +: 8];
            end else bad = 1;
         end
         rvde_pkg::OPC_ALUI: begin has_rd = 1; val = alu_op(f3, alt, a, sext_i(w), 0); end
         rvde_pkg::OPC_ALUR: begin has_rd = 1; val = alu_op(f3, alt, a, b, 1); end
         default: bad = 1;
      endcase
      if (bad) begin
         r.illegal = 1;
         return r;
      end
      if (has_rd && rd != 0) begin
         regs[rd] = val;
         r.dest_index = rd;
         r.dest_value = val;
         r.dest_written = 1;
      end
      pc = npc;
      r.next_pc = npc;
      return r;
   endfunction

   int mismatches;
   assign fail_count = mismatches;
   assign pending = expected_q.size();

   always @(posedge clock) begin
      rvde_pkg::result_type got, want;
      if (reset) begin
         pc = 0;
         for (int i = 0; i < 32; i++) regs[i] = 0;
         expected_q.delete();
      end else begin
         if (csr_write_enable) pc = csr_write_data;
         if (req_valid && req_ready)
            expected_q.push_back(execute_request(req_command, req_instr_word,
                                                 req_preload_addr, req_preload_byte));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_next_pc, rsp_dest_index, rsp_dest_value, rsp_dest_written,
                    rsp_illegal};
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end

   initial mismatches = 0;
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the rv32i_decode_execute testbench: clock, reset, stimulus, verdict.
// Depends on rvde_pkg, rvde_checker and the block itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock, reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;
   logic        req_valid, req_ready, req_command;
   logic [31:0] req_instr_word;
   logic [15:0] req_preload_addr;
   logic [7:0]  req_preload_byte;
   logic        rsp_valid, rsp_ready;
   logic [31:0] rsp_next_pc, rsp_dest_value;
   logic [4:0]  rsp_dest_index;
   logic        rsp_dest_written, rsp_illegal;
   int          fail_count, pending;
   int          send_idle, recv_idle;
   // addresses written so far; loads read only these
   bit          written [logic [15:0]];
   logic [15:0] written_list [$];

   rv32i_decode_execute dut (.*);
   rvde_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle);

   // Hold valid until accepted; drop it only while idling.
   task automatic send_request(logic cmd, logic [31:0] w, logic [15:0] pa, logic [7:0] pb);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_instr_word <= w;
      req_preload_addr <= pa;
      req_preload_byte <= pb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic poke_byte(logic [15:0] a, logic [7:0] v);
      if (!written.exists(a)) written_list.push_back(a);
      written[a] = 1;
      send_request(1, $urandom, a, v);
   endtask

   task automatic exec(logic [31:0] w);
      send_request(0, w, 16'($urandom), 8'($urandom));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_start_pc(logic [31:0] v);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, opc};
   endfunction

   // Random instruction; loads and stores use x0 base so addresses stay known.
   task automatic random_instr();
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      logic [15:0] a;
      int          pick;
      rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom); f3 = 3'($urandom);
      pick = $urandom_range(11);
      case (pick)
         0: exec({20'($urandom_range(32'hfffff)), rd, rvde_pkg::OPC_LUI});
         1: exec({20'($urandom_range(32'hfffff)), rd, rvde_pkg::OPC_AUIPC});
         2: exec({20'($urandom_range(32'hfffff)), rd, rvde_pkg::OPC_JAL});
         3: exec({12'($urandom_range(12'hfff)), rs1, f3, rd, rvde_pkg::OPC_JALR});
         4: exec({7'($urandom_range(7'h7f)), rs2, rs1, f3, 5'($urandom_range(5'h1f)),
                  rvde_pkg::OPC_BRANCH});
         5, 6: begin
            if (written_list.size() < 4) poke_byte(16'($urandom), 8'($urandom));
            else begin
               // word loads need four known bytes; fall back to halfword or byte loads
               a = written_list[$urandom_range(written_list.size() - 1)];
               f3 = $urandom_range(1) ? rvde_pkg::F3_LBU : rvde_pkg::F3_LB;
               if (written.exists(16'(a + 1)))
                  f3 = $urandom_range(1) ? rvde_pkg::F3_LHU : rvde_pkg::F3_LH;
               if (written.exists(16'(a + 1)) && written.exists(16'(a + 2)) &&
                   written.exists(16'(a + 3)))
                  f3 = rvde_pkg::F3_LW;
               if (a < 16'h800 || a >= 16'hf800)
                  exec(enc_i(rvde_pkg::OPC_LOAD, f3, rd, 5'd0, 12'(a)));
               else poke_byte(16'($urandom), 8'($urandom));
            end
         end
         7: begin
            a = 16'($urandom_range(16'h7fc));
            f3 = 3'($urandom_range(2));
            exec({7'(a >> 5), rs2, 5'd0, f3, 5'(a), rvde_pkg::OPC_STORE});
            for (int i = 0; i < (1 << f3); i++)
               if (!written.exists(16'(a + i))) begin
                  written[16'(a + i)] = 1;
                  written_list.push_back(16'(a + i));
               end
         end
         8, 9: exec({12'($urandom_range(12'hfff)), rs1, f3, rd, rvde_pkg::OPC_ALUI});
         10: exec({7'($urandom_range(7'h7f)), rs2, rs1, f3, rd, rvde_pkg::OPC_ALUR});
         default: begin
            if ($urandom_range(1)) poke_byte(16'($urandom), 8'($urandom));
            else exec({25'($urandom_range(32'h1ffffff)), 7'($urandom)} | 32'h0000_0008);
         end
      endcase
   endtask

   initial begin
      reset = 1;
      csr_write_enable = 0; csr_write_data = 0;
      req_valid = 0; req_command = 0; req_instr_word = 0;
      req_preload_addr = 0; req_preload_byte = 0;
      rsp_ready = 0;
      send_idle = 28; recv_idle = 45;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every class but a legal store, illegal encodings, x0 destination
      poke_byte(16'hffff, 8'h80);
      poke_byte(16'h0000, 8'hff);
      poke_byte(16'h0001, 8'h7f);
      poke_byte(16'h0002, 8'h01);
      exec(32'hfffff0b7);                              // lui x1
      exec(32'h80000117);                              // auipc x2
      exec(enc_i(rvde_pkg::OPC_ALUI, rvde_pkg::F3_ADD, 5'd3, 5'd0, 12'h7ff));
      exec(enc_i(rvde_pkg::OPC_ALUI, rvde_pkg::F3_ADD, 5'd0, 5'd1, 12'h800)); // write x0
      exec(enc_i(rvde_pkg::OPC_LOAD, rvde_pkg::F3_LW, 5'd0, 5'd0, 12'hfff));  // x0, wraps
      exec(enc_i(rvde_pkg::OPC_LOAD, rvde_pkg::F3_LH, 5'd4, 5'd0, 12'hfff));
      exec(enc_i(rvde_pkg::OPC_LOAD, rvde_pkg::F3_LB, 5'd5, 5'd0, 12'hfff));
      exec(enc_i(rvde_pkg::OPC_ALUI, rvde_pkg::F3_SR, 5'd6, 5'd1, 12'h404)); // srai
      exec({7'h7f, 5'd3, 5'd1, rvde_pkg::F3_SR, 5'd7, rvde_pkg::OPC_ALUR}); // odd funct7
      exec({7'h20, 5'd3, 5'd1, rvde_pkg::F3_ADD, 5'd8, rvde_pkg::OPC_ALUR}); // sub
      exec({7'h7f, 5'd1, 5'd2, rvde_pkg::F3_BLTU, 5'h1f, rvde_pkg::OPC_BRANCH});
      exec({7'h00, 5'd1, 5'd2, 3'd2, 5'd0, rvde_pkg::OPC_BRANCH});  // illegal branch
      exec(enc_i(rvde_pkg::OPC_LOAD, 3'd3, 5'd9, 5'd0, 12'd0));      // illegal load
      exec({7'd0, 5'd1, 5'd0, 3'd3, 5'd0, rvde_pkg::OPC_STORE});     // illegal store
      exec(32'hffffffff);
      exec({20'h80001, 5'd10, rvde_pkg::OPC_JAL});
      exec(enc_i(rvde_pkg::OPC_JALR, 3'd5, 5'd11, 5'd3, 12'hfff));
      drain();
      write_start_pc(32'hffff_fffc);
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin send_idle = 45; recv_idle = 28; end
         if (phase == 2) begin send_idle = 0; recv_idle = 0; end
         for (int n = 0; n < 235; n++) random_instr();
         drain();
         write_start_pc(phase == 0 ? 32'h0 : $urandom);
      end
      drain();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
